[rtl/core/wsfd_pkg.sv]
// shared types and constants of the wheel speed frame decoder
`default_nettype none

package wsfd_pkg;

  localparam int FRAME_LENGTH_DEFAULT = 13;
  localparam int BYTE_W = 8;
  localparam int SPEED_W = 16;
  localparam int THRESH_W = 16;
  localparam int POS_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_WHEELS = 4;
  localparam int PAYLOAD_BYTES = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] FIRST_PAYLOAD_POS = 4'd2;
  localparam logic [POS_W-1:0] LAST_PAYLOAD_POS = 4'd9;
  localparam logic [POS_W-1:0] CHECKSUM_POS = 4'd10;

  localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RESET = 16'd1500;
  localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET = 8'h5A;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET = 8'hA5;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_JUMP_THRESHOLD = 2'd0,
    CFG_FIRST_HEADER   = 2'd1,
    CFG_SECOND_HEADER  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic                                 bad;
    logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[rtl/core/wsfd_front.sv]
// header hunt, frame collection and checksum check
`default_nettype none

module wsfd_front import wsfd_pkg::*; #(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [BYTE_W-1:0]   first_header,
  input  wire logic [BYTE_W-1:0]   second_header,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BYTE_W-1:0]   in_byte,
  input  wire queue_status_t       qstat,
  output logic                     push,
  output frame_t                   push_frame
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  phase_t                               phase, phase_next;
  logic [POS_W-1:0]                     pos, pos_next;
  logic [BYTE_W-1:0]                    sum, sum_next;
  logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload;
  logic [BYTE_W-1:0]                    checksum;
  logic [BYTE_W-1:0]                    chk_now;
  logic [2:0]                           slot;
  logic                                 accept;
  logic                                 is_payload;

  assign in_ready = !qstat.full;
  assign accept = in_valid && in_ready;
  assign is_payload = (pos >= FIRST_PAYLOAD_POS) && (pos <= LAST_PAYLOAD_POS);
  assign slot = 3'(pos - FIRST_PAYLOAD_POS);
  assign chk_now = (pos == CHECKSUM_POS) ? in_byte : checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos <= '0;
      sum <= '0;
    end else begin
      phase <= phase_next;
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // frame bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && phase == PH_COLLECT) begin
      if (is_payload) begin
        payload[slot] <= in_byte;
      end
      if (pos == CHECKSUM_POS) begin
        checksum <= in_byte;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    sum_next = sum;
    push = 1'b0;
    push_frame.payload = payload;
    push_frame.bad = (chk_now != sum);
    unique case (phase)
      PH_HUNT: begin
        if (accept && in_byte == first_header) begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (accept) begin
          if (in_byte == second_header) begin
            phase_next = PH_COLLECT;
            pos_next = FIRST_PAYLOAD_POS;
            sum_next = '0;
          end else if (in_byte != first_header) begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_COLLECT: begin
        if (accept) begin
          if (is_payload) begin
            sum_next = sum + in_byte;
          end
          if (pos < LAST_POS) begin
            pos_next = pos + 4'd1;
          end else begin
            phase_next = PH_HUNT;
            pos_next = '0;
            push = 1'b1;
          end
        end
      end
      default: begin
        if (accept) begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/wsfd_queue.sv]
// short frame queue between collection and decode
`default_nettype none

module wsfd_queue import wsfd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire frame_t  push_frame,
  input  wire logic    pop,
  output frame_t       head,
  output queue_status_t qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head = entries[rd_ptr];
  assign qstat.full = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wsfd_back.sv]
// speed decode, per-wheel jump filter and result register
`default_nettype none

module wsfd_back import wsfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [THRESH_W-1:0]  threshold,
  input  wire frame_t               head,
  input  wire queue_status_t        qstat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_bad,
  output logic [SPEED_W-1:0]        speed [NUM_WHEELS]
);

  logic [SPEED_W-1:0]  prev [NUM_WHEELS];
  logic [SPEED_W-1:0]  now_v [NUM_WHEELS];
  logic [SPEED_W-1:0]  filt_v [NUM_WHEELS];
  logic [SPEED_W-1:0]  mag [NUM_WHEELS];
  logic [SPEED_W:0]    diff [NUM_WHEELS];
  logic [SPEED_W:0]    absdiff [NUM_WHEELS];
  logic [BYTE_W-1:0]   hi [NUM_WHEELS];
  logic [BYTE_W-1:0]   lo [NUM_WHEELS];
  logic                load;

  assign load = !qstat.empty && (!out_valid || out_ready);
  assign pop = load;

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      hi[w] = head.payload[2*w];
      lo[w] = head.payload[2*w+1];
      mag[w] = {1'b0, hi[w][6:0], lo[w]};
      // sign-magnitude to two's complement
      now_v[w] = hi[w][7] ? (SPEED_W'(0) - mag[w]) : mag[w];
      diff[w] = {now_v[w][SPEED_W-1], now_v[w]} - {prev[w][SPEED_W-1], prev[w]};
      absdiff[w] = diff[w][SPEED_W] ? ((SPEED_W+1)'(0) - diff[w]) : diff[w];
      filt_v[w] = (absdiff[w] < {1'b0, threshold}) ? prev[w] : now_v[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        prev[w] <= '0;
        speed[w] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (!head.bad) begin
          for (int w = 0; w < NUM_WHEELS; w++) begin
            prev[w] <= now_v[w];
            speed[w] <= filt_v[w];
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bad <= head.bad;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wheel_speed_frame_decoder.sv]
// top level of the wheel speed frame decoder
`default_nettype none

// Accepts one received byte per cycle on the slave stream. The front end hunts
// for the two header bytes, collects the frame and checks the payload sum; each
// completed frame goes through a two-entry queue to the back end, which decodes
// the four sign-magnitude wheel speeds, runs each through its own jump filter
// and holds the result in an output register. The last byte of a frame writes
// its queue entry, and the result register loads from the queue when free; the
// output register and the queue let bytes keep flowing while a result waits,
// and input stalls only when the queue is full. tuser carries the frame status:
// 1 means checksum mismatch, with the speeds of the last good frame repeated.

module wheel_speed_frame_decoder import wsfd_pkg::*; #(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [7:0]              s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [63:0]                  m_tdata,   // [15:0] left_front_speed,
                                                  // [31:16] right_front_speed,
                                                  // [47:32] left_back_speed,
                                                  // [63:48] right_back_speed
  output logic                         m_tuser,   // [0] frame_status
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [THRESH_W-1:0] jump_threshold;
  logic [BYTE_W-1:0]   first_header_byte;
  logic [BYTE_W-1:0]   second_header_byte;

  logic                push;
  logic                pop;
  frame_t              push_frame;
  frame_t              head;
  queue_status_t       qstat;
  logic [SPEED_W-1:0]  speed [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= JUMP_THRESHOLD_RESET;
      first_header_byte <= FIRST_HEADER_RESET;
      second_header_byte <= SECOND_HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JUMP_THRESHOLD: jump_threshold <= cfg_data;
        CFG_FIRST_HEADER:   first_header_byte <= cfg_data[BYTE_W-1:0];
        CFG_SECOND_HEADER:  second_header_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  wsfd_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .first_header  (first_header_byte),
    .second_header (second_header_byte),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata),
    .qstat         (qstat),
    .push          (push),
    .push_frame    (push_frame)
  );

  wsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  wsfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (jump_threshold),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bad   (m_tuser),
    .speed     (speed)
  );

  assign m_tdata = {speed[3], speed[2], speed[1], speed[0]};

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("frame pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("frame popped from an empty queue");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !s_tready)
    else $error("input taken while queue full");

endmodule

`default_nettype wire

[dv/tb_wheel_speed_frame_decoder.sv]
// self-checking testbench of the wheel speed frame decoder: byte stream in, filtered speeds out
module tb_wheel_speed_frame_decoder;
  import wsfd_pkg::*;

  localparam int FRAME_LEN = FRAME_LENGTH_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BYTES = 250;
  localparam int NUM_PHASES = 6;
  localparam int NUM_DIRECTED = 30;

  typedef struct packed {
    logic        status;
    logic [63:0] speeds;   // {right_back, left_back, right_front, left_front}
  } speed_report_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    logic        status;
    logic [63:0] speeds;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;            // [15:0] lf, [31:16] rf, [47:32] lb, [63:48] rb speed
  logic        m_tuser;            // [0] frame_status
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_JUMP_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  wheel_speed_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // decoder copy
  int unsigned  jump_thr;
  logic [7:0]   hdr_first;
  logic [7:0]   hdr_second;
  phase_t       rx_phase;
  logic [3:0]   rx_pos;
  logic [7:0]   rx_sum;
  logic [7:0]   rx_payload [PAYLOAD_BYTES];
  logic [7:0]   rx_check;
  int           prev_speed [NUM_WHEELS];
  int           held_speed [NUM_WHEELS];

  speed_report_t speed_reports_q [$];
  speed_report_t want;
  int            error_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  int            stall_mode = 0;
  int            stall_left = 0;
  string         wheel_names [NUM_WHEELS] = '{"left_front_speed", "right_front_speed",
                                               "left_back_speed", "right_back_speed"};

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h12, 1'b0, 1'b0, 64'h0},
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'h33, 1'b0, 1'b0, 64'h0},
    // header repeat, then extremes and negative zero
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'hA5, 1'b0, 1'b0, 64'h0},
    '{8'h7F, 1'b0, 1'b0, 64'h0},
    '{8'hFF, 1'b0, 1'b0, 64'h0},
    '{8'hFF, 1'b0, 1'b0, 64'h0},
    '{8'hFF, 1'b0, 1'b0, 64'h0},
    '{8'h80, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h01, 1'b0, 1'b0, 64'h0},
    '{8'hFD, 1'b0, 1'b0, 64'h0},
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'hA5, 1'b1, 1'b0, 64'h0000_0000_8001_7FFF},
    // header bytes as payload, bad checksum holds the speeds
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'hA5, 1'b0, 1'b0, 64'h0},
    '{8'h5A, 1'b0, 1'b0, 64'h0},
    '{8'hA5, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b0, 1'b0, 64'h0},
    '{8'h00, 1'b1, 1'b1, 64'h0000_0000_8001_7FFF}
  };

  function automatic bit decode_rx_byte(input logic [7:0] b, output speed_report_t rep);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [14:0] mag;
    int          s;
    int          diff;
    rep = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == hdr_first) rx_phase = PH_SECOND;
        return 1'b0;
      end
      PH_SECOND: begin
        if (b == hdr_second) begin
          rx_phase = PH_COLLECT;
          rx_pos = FIRST_PAYLOAD_POS;
          rx_sum = 8'h00;
        end else if (b != hdr_first) begin
          rx_phase = PH_HUNT;
        end
        return 1'b0;
      end
      PH_COLLECT: begin
        if (rx_pos >= FIRST_PAYLOAD_POS && rx_pos <= LAST_PAYLOAD_POS) begin
          rx_payload[rx_pos - FIRST_PAYLOAD_POS] = b;
          rx_sum = rx_sum + b;
        end else if (rx_pos == CHECKSUM_POS) begin
          rx_check = b;
        end
        if (rx_pos < FRAME_LEN - 1) begin
          rx_pos = rx_pos + 4'd1;
          return 1'b0;
        end
        rx_phase = PH_HUNT;
        rx_pos = 4'd0;
        rep.status = (rx_check != rx_sum);
        if (!rep.status) begin
          for (int w = 0; w < NUM_WHEELS; w++) begin
            hi = rx_payload[2*w];
            lo = rx_payload[2*w+1];
            mag = {hi[6:0], lo};
            s = hi[7] ? -int'(mag) : int'(mag);
            diff = s - prev_speed[w];
            if (diff < 0) diff = -diff;
            held_speed[w] = (diff < int'(jump_thr)) ? prev_speed[w] : s;
            prev_speed[w] = s;
          end
        end
        for (int w = 0; w < NUM_WHEELS; w++) rep.speeds[16*w +: 16] = held_speed[w][15:0];
        return 1'b1;
      end
      default: begin
        rx_phase = PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input speed_report_t typed_rep);
    int            gap;
    int            r;
    speed_report_t rep;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      gap = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 6) : $urandom_range(10, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    if (decode_rx_byte(b, rep)) speed_reports_q.push_back(use_typed ? typed_rep : rep);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  // sign-magnitude code of a wheel speed, often close to the last one
  function automatic logic [15:0] pick_speed_code(input int last);
    int v;
    int span;
    int mag;
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      3: return 16'h8000;
      4: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'hFFFF;
      default: begin
        span = 2 * int'(jump_thr) + 2;
        if (span > 70000) span = 70000;
        v = last + $urandom_range(0, span) - span / 2;
        if (v > 32767) v = 32767;
        if (v < -32767) v = -32767;
        mag = (v < 0) ? -v : v;
        return {v < 0, 15'(mag)};
      end
    endcase
  endfunction

  task automatic send_frame(output int sent);
    logic [7:0]  frame_q [$];
    logic [15:0] code;
    logic [7:0]  sum;
    frame_q.push_back(hdr_first);
    if (hdr_first != hdr_second && $urandom_range(0, 7) == 0) frame_q.push_back(hdr_first);
    frame_q.push_back(hdr_second);
    sum = 8'h00;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      code = pick_speed_code(prev_speed[w]);
      frame_q.push_back(code[15:8]);
      frame_q.push_back(code[7:0]);
      sum = sum + code[15:8] + code[7:0];
    end
    if ($urandom_range(0, 6) == 0) frame_q.push_back(sum + 8'($urandom_range(1, 255)));
    else frame_q.push_back(sum);
    for (int i = CHECKSUM_POS + 1; i < FRAME_LEN; i++) frame_q.push_back(8'($urandom));
    sent = frame_q.size();
    foreach (frame_q[i]) send_data(frame_q[i]);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (speed_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_JUMP_THRESHOLD: jump_thr = val;
      CFG_FIRST_HEADER:   hdr_first = val[7:0];
      CFG_SECOND_HEADER:  hdr_second = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] thr, input logic [7:0] h1, input logic [7:0] h2);
    write_reg(CFG_JUMP_THRESHOLD, thr);
    write_reg(CFG_FIRST_HEADER, {8'h00, h1});
    write_reg(CFG_SECOND_HEADER, {8'h00, h2});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (speed_reports_q.size() == 0) begin
        $error("unexpected result transaction: status %0b speeds %h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = speed_reports_q.pop_front();
        if (want.status !== m_tuser) begin
          $error("frame_status expected %0b got %0b", want.status, m_tuser);
          error_count++;
        end
        for (int w = 0; w < NUM_WHEELS; w++) begin
          if (want.speeds[16*w +: 16] !== m_tdata[16*w +: 16]) begin
            $error("%s expected %0d got %0d", wheel_names[w],
                   $signed(want.speeds[16*w +: 16]), $signed(m_tdata[16*w +: 16]));
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_wheel_speed_frame_decoder NOT OK");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase_count;
    int r;
    speed_report_t typed_rep;
    jump_thr = JUMP_THRESHOLD_RESET;
    hdr_first = FIRST_HEADER_RESET;
    hdr_second = SECOND_HEADER_RESET;
    rx_phase = PH_HUNT;
    rx_pos = 4'd0;
    rx_sum = 8'h00;
    rx_check = 8'h00;
    foreach (rx_payload[i]) rx_payload[i] = 8'h00;
    foreach (prev_speed[i]) prev_speed[i] = 0;
    foreach (held_speed[i]) held_speed[i] = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_rep.status = directed_rows[i].status;
      typed_rep.speeds = directed_rows[i].speeds;
      send_byte(directed_rows[i].data, directed_rows[i].typed, typed_rep);
    end

    for (int p = 1; p <= NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        1: configure(16'd0, 8'h5A, 8'hA5);
        2: configure(16'hFFFF, 8'h00, 8'hFF);
        3: configure(16'($urandom_range(100, 3000)), 8'h3C, 8'h3C);
        4: configure(16'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom));
        5: configure(16'd1500, 8'hFF, 8'h00);
        default: configure(16'($urandom), 8'($urandom), 8'($urandom));
      endcase
      phase_count = 0;
      while (phase_count < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          repeat ($urandom_range(1, 4)) send_data(8'($urandom));
        end else if (r == 1) begin
          send_data(hdr_first);
          send_data(8'($urandom));
        end
        send_frame(sent);
        phase_count += sent;
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("tb_wheel_speed_frame_decoder OK");
    end else begin
      $display("tb_wheel_speed_frame_decoder NOT OK");
    end
    $finish;
  end

endmodule
